// ===== rtl/core/uft_pkg.sv =====
// shared types and constants for the uart frame transmitter
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package uft_pkg;

	localparam int FRAME_W = 13;
	localparam int CNT_W   = 4;

	typedef enum logic [1:0] {
		PH_STOPPED,
		PH_IDLE,
		PH_SEND,
		PH_END
	} phase_t;

	// register indexes on the config port
	localparam logic [1:0] REG_TX_ENABLE   = 2'd0;
	localparam logic [1:0] REG_DATA_BITS   = 2'd1;
	localparam logic [1:0] REG_PARITY_MODE = 2'd2;
	localparam logic [1:0] REG_STOP_BITS   = 2'd3;

	// parity modes, any other code means no parity
	localparam logic [1:0] PAR_EVEN = 2'd1;
	localparam logic [1:0] PAR_ODD  = 2'd2;

	localparam logic [CNT_W-1:0] MIN_DATA_BITS = 4'd5;
	localparam logic [CNT_W-1:0] MAX_DATA_BITS = 4'd9;

	typedef struct packed {
		logic             tx_enable;
		logic [CNT_W-1:0] data_bits;
		logic [1:0]       parity_mode;
		logic [1:0]       stop_bits;
	} cfg_t;

	typedef struct packed {
		logic change;
		logic value;
	} en_evt_t;

	typedef struct packed {
		logic [FRAME_W-1:0] shift;
		logic [CNT_W-1:0]   length;
	} frame_t;

	typedef struct packed {
		logic       line_level;
		logic       busy_res;
		logic       load_taken;
		logic       frame_done;
		logic [7:0] sent_byte;
	} result_t;

endpackage

// ===== rtl/core/uft_frame_build.sv =====
// builds the serial frame (start, data, parity, stop bits) for a load word
// depends on uft_pkg
`timescale 1ns / 1ps

module uft_frame_build (
	input  uft_pkg::cfg_t   cfg,
	input  logic [7:0]      data_byte,
	input  logic            ninth_bit,
	output uft_pkg::frame_t frame
);
	import uft_pkg::*;

	logic [CNT_W-1:0]   nb;
	logic [1:0]         sb;
	logic [7:0]         mask8;
	logic [7:0]         masked;
	logic               par_en;
	logic               par_bit;
	logic [CNT_W-1:0]   len;
	logic [FRAME_W-1:0] shift;
	logic [FRAME_W-1:0] stop_mask;

	always_comb begin
		nb = cfg.data_bits;
		if (nb < MIN_DATA_BITS) begin
			nb = MIN_DATA_BITS;
		end else if (nb > MAX_DATA_BITS) begin
			nb = MAX_DATA_BITS;
		end

		if (cfg.stop_bits == 2'd0) begin
			sb = 2'd1;
		end else if (cfg.stop_bits == 2'd3) begin
			sb = 2'd2;
		end else begin
			sb = cfg.stop_bits;
		end

		mask8  = (nb >= 4'd8) ? 8'hFF : (8'hFF >> (4'd8 - nb));
		masked = data_byte & mask8;

		// start bit sits in bit 0 as a zero
		shift = {4'b0000, masked, 1'b0};
		if (nb == MAX_DATA_BITS) begin
			shift[9] = ninth_bit;
		end
		len = nb + 4'd1;

		par_en  = (cfg.parity_mode == PAR_EVEN) || (cfg.parity_mode == PAR_ODD);
		par_bit = (^masked) ^ (cfg.parity_mode == PAR_ODD);
		if (par_en) begin
			shift = shift | (FRAME_W'(par_bit) << len);
			len   = len + 4'd1;
		end

		stop_mask = (sb == 2'd2) ? FRAME_W'(2'b11) : FRAME_W'(2'b01);
		shift     = shift | (stop_mask << len);
		len       = len + {2'b00, sb};

		frame.shift  = shift;
		frame.length = len;
	end

endmodule

// ===== rtl/core/uft_tx_core.sv =====
// transmitter state: phase machine, frame shifter, bit counter and line level
// depends on uft_pkg and uft_frame_build
`timescale 1ns / 1ps

module uft_tx_core (
	input  logic             clk,
	input  logic             arst_n,
	input  uft_pkg::cfg_t    cfg,
	input  uft_pkg::en_evt_t en_evt,
	input  logic             step,
	input  logic             operation,
	input  logic [7:0]       data_byte,
	input  logic             ninth_bit,
	output uft_pkg::result_t result
);
	import uft_pkg::*;

	phase_t             phase_q, phase_d;
	logic [FRAME_W-1:0] shift_q, shift_d;
	logic [CNT_W-1:0]   bit_count_q, bit_count_d;
	logic [CNT_W-1:0]   length_q, length_d;
	logic               line_q, line_d;
	logic [7:0]         byte_q, byte_d;
	logic [CNT_W-1:0]   count_inc;
	logic               taken;
	logic               done;
	frame_t             frame;

	uft_frame_build u_build (
		.cfg       (cfg),
		.data_byte (data_byte),
		.ninth_bit (ninth_bit),
		.frame     (frame)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_STOPPED;
			shift_q     <= '0;
			bit_count_q <= '0;
			length_q    <= '0;
			line_q      <= 1'b1;
			byte_q      <= '0;
		end else begin
			phase_q     <= phase_d;
			shift_q     <= shift_d;
			bit_count_q <= bit_count_d;
			length_q    <= length_d;
			line_q      <= line_d;
			byte_q      <= byte_d;
		end
	end

	always_comb begin
		phase_d     = phase_q;
		shift_d     = shift_q;
		bit_count_d = bit_count_q;
		length_d    = length_q;
		line_d      = line_q;
		byte_d      = byte_q;
		count_inc   = bit_count_q + 4'd1;
		taken       = 1'b0;
		done        = 1'b0;

		if (en_evt.change) begin
			phase_d = en_evt.value ? PH_IDLE : PH_STOPPED;
			line_d  = 1'b1;
		end else if (step) begin
			if (operation) begin
				if (cfg.tx_enable && (phase_q == PH_IDLE)) begin
					// start bit goes out at once
					line_d      = frame.shift[0];
					shift_d     = frame.shift >> 1;
					bit_count_d = 4'd1;
					length_d    = frame.length;
					phase_d     = (frame.length == 4'd1) ? PH_END : PH_SEND;
					byte_d      = data_byte;
					taken       = 1'b1;
				end
			end else begin
				case (phase_q)
					PH_SEND: begin
						line_d      = shift_q[0];
						shift_d     = shift_q >> 1;
						bit_count_d = count_inc;
						if (count_inc == length_q) begin
							phase_d = PH_END;
						end
					end
					PH_END: begin
						phase_d = PH_IDLE;
						line_d  = 1'b1;
						done    = 1'b1;
					end
					default: begin
					end
				endcase
			end
		end

		result.line_level = line_d;
		result.busy_res   = (phase_d == PH_SEND) || (phase_d == PH_END);
		result.load_taken = taken;
		result.frame_done = done;
		result.sent_byte  = done ? byte_q : 8'h00;
	end

`ifndef SYNTHESIS
	a_count_below_length: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SEND) |-> (bit_count_q < length_q))
		else $error("bit counter reached frame length while sending");

	a_idle_line_high: assert property (@(posedge clk) disable iff (!arst_n)
		((phase_q == PH_IDLE) || (phase_q == PH_STOPPED)) |-> line_q)
		else $error("line not idle high outside a frame");

	a_done_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !en_evt.change && !operation && (phase_q == PH_END)) |=>
		((phase_q == PH_IDLE) && line_q))
		else $error("frame end did not return to idle");
`endif

endmodule

// ===== rtl/core/uart_frame_transmitter.sv =====
// top level of the uart frame transmitter: config registers, input and output stages
// depends on uft_pkg and uft_tx_core
`timescale 1ns / 1ps

// One word per clock in both directions unless the result stream stalls. An input word
// is registered in the input stage, processed against the transmitter state once the
// output register is free or being taken, and its result is written to the output
// register. The input stage refills while a finished result waits, so the block stalls
// only when the output register is full and not taken. A tick word (tuser 0) shifts out
// one frame bit while sending or ends the frame after its last bit; a load word
// (tuser 1) starts a frame only when enabled and idle. The config port is ready only
// while the input stage is empty, so a register write never lands on a word in process.
module uart_frame_transmitter (
	input  logic        clk,
	input  logic        arst_n,
	// config write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [3:0]  cfg_data,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [7:0] data_byte, [8] ninth_bit, [15:9] zero
	input  logic        s_axis_tuser,  // [0] operation
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata   // [0] line_level, [1] busy_res, [2] load_taken,
	                                   // [3] frame_done, [11:4] sent_byte, [15:12] zero
);
	import uft_pkg::*;

	cfg_t       cfg_q;
	en_evt_t    en_evt;
	logic       cfg_wr;

	logic       valid_s1;
	logic       op_s1;
	logic [7:0] byte_s1;
	logic       bit9_s1;
	logic       advance;

	result_t    result;
	logic       out_valid_q;
	logic [15:0] out_data_q;

	assign cfg_ready = !valid_s1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tx_enable   <= 1'b0;
			cfg_q.data_bits   <= 4'd8;
			cfg_q.parity_mode <= 2'd0;
			cfg_q.stop_bits   <= 2'd1;
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_TX_ENABLE:   cfg_q.tx_enable   <= cfg_data[0];
				REG_DATA_BITS:   cfg_q.data_bits   <= cfg_data;
				REG_PARITY_MODE: cfg_q.parity_mode <= cfg_data[1:0];
				REG_STOP_BITS:   cfg_q.stop_bits   <= cfg_data[1:0];
				default: begin
				end
			endcase
		end
	end

	// only a real change of the enable moves the phase
	assign en_evt.change = cfg_wr && (cfg_index == REG_TX_ENABLE) &&
		(cfg_data[0] != cfg_q.tx_enable);
	assign en_evt.value  = cfg_data[0];

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_s1   <= s_axis_tuser;
			byte_s1 <= s_axis_tdata[7:0];
			bit9_s1 <= s_axis_tdata[8];
		end
	end

	uft_tx_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.en_evt    (en_evt),
		.step      (advance),
		.operation (op_s1),
		.data_byte (byte_s1),
		.ninth_bit (bit9_s1),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {4'b0000, result.sent_byte, result.frame_done,
				result.load_taken, result.busy_res, result.line_level};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && out_valid_q && !m_axis_tready))
		else $error("input stalled without a blocked result");

	a_taken_done_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_data_q[2] && out_data_q[3]))
		else $error("load taken and frame done in one result");

	a_done_line_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q[3]) |-> (out_data_q[0] && !out_data_q[1]))
		else $error("frame done with line low or still busy");

	a_taken_starts_low: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q[2]) |-> (!out_data_q[0] && out_data_q[1]))
		else $error("load taken without start bit on the line");
`endif

endmodule
